### rtl/numfmt_pkg.sv
// ----------------------------------------------------------------------------
// numfmt_pkg
// Shared constants and helpers for the number-to-ASCII formatter: format
// codes, ASCII codes, BCD register geometry and the hex digit encoder.
// ----------------------------------------------------------------------------
package numfmt_pkg;

   // Format selector codes
   localparam logic [1:0] FMT_SIGNED_DEC = 2'd0;
   localparam logic [1:0] FMT_DEC4       = 2'd1;
   localparam logic [1:0] FMT_BIN8       = 2'd2;
   localparam logic [1:0] FMT_HEX8       = 2'd3;

   // ASCII codes
   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_MINUS = 7'h2D;
   localparam logic [6:0] ASCII_UPPER_A = 7'h41;
   localparam logic [6:0] ASCII_UPPER_X = 7'h58;

   // Geometry
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
   localparam int unsigned CHAR_W     = 7;

   typedef logic [BCD_W-1:0]   bcd_type;
   typedef logic [VALUE_W-1:0] word_type;
   typedef logic [CHAR_W-1:0]  char_type;

   // Map one nibble to its upper-case hex character
   function automatic char_type hex_char(input logic [3:0] nib);
      char_type c;
      if (nib > 4'd9) begin
         c = ASCII_UPPER_A + {3'b000, nib - 4'd10};
      end else begin
         c = ASCII_ZERO + {3'b000, nib};
      end
      return c;
   endfunction

endpackage

### rtl/numfmt_if.sv
// ----------------------------------------------------------------------------
// numfmt channel interfaces
// Valid/ready channels for the formatter: number request and character
// response.
// ----------------------------------------------------------------------------
interface numfmt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface numfmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

### rtl/numfmt_dabble_step.sv
// ----------------------------------------------------------------------------
// numfmt_dabble_step
// One double-dabble iteration: add three to every BCD digit of five or more,
// then shift the BCD register left by one and take in the next binary bit.
// ----------------------------------------------------------------------------
module numfmt_dabble_step (
   input  numfmt_pkg::bcd_type bcd_cur,
   input  logic                bit_in,
   output numfmt_pkg::bcd_type bcd_next
);
   import numfmt_pkg::*;

   bcd_type adj;

   // Correct each digit independently
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_cur[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_cur[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_cur[4*i +: 4];
         end
      end
   end

   // Shift in the next bit, most significant first
   assign bcd_next = {adj[BCD_W-2:0], bit_in};

endmodule

### rtl/number_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_unit
// Formats one number per request as ASCII characters (signed decimal,
// four-digit decimal, binary byte, hex byte), one character per response.
// ----------------------------------------------------------------------------
//  channel | dir | payload               | accepted when
//  req     | in  | action[1:0], value[31:0] | req.valid && req.ready
//  rsp     | out | char_code[6:0], last  | rsp.valid && rsp.ready
//
//  Decimal formats run a bit-serial double dabble, one bit per cycle, over
//  all 32 bits for signed decimal and 16 bits for four-digit decimal.
//  Signed decimal then drops up to nine leading zeros. Characters leave
//  one per cycle from the output register unless the response stalls;
//  every dropped zero is one character fewer. Binary and hex skip the
//  conversion. One item is in work at a time.
//  A stalled response holds the register and pauses emission. Reset
//  (synchronous) returns the unit to idle and drops any pending response.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_unit (
   input logic         clock,
   input logic         reset,
   numfmt_req_if.sink   req_chan,
   numfmt_rsp_if.source rsp_chan
);
   import numfmt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff,  state_in;
   logic [1:0] mode_ff,   mode_in;
   logic       neg_ff,    neg_in;
   word_type   bin_ff,    bin_in;
   bcd_type    bcd_ff,    bcd_in;
   logic [4:0] cnt_ff,    cnt_in;
   logic [3:0] dig_ff,    dig_in;
   logic [1:0] pre_ff,    pre_in;

   logic       rsp_valid_ff, rsp_valid_in;
   char_type   rsp_char_ff,  rsp_char_in;
   logic       rsp_last_ff,  rsp_last_in;

   bcd_type    bcd_step;
   bcd_type    bin_nibbles;
   logic       slot_free;
   word_type   value_mag;

   numfmt_dabble_step u_dabble (
      .bcd_cur  (bcd_ff),
      .bit_in   (bin_ff[VALUE_W-1]),
      .bcd_next (bcd_step)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.char_code = rsp_char_ff;
   assign rsp_chan.last      = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign value_mag = req_chan.value[VALUE_W-1] ? (~req_chan.value + 32'd1)
                                                : req_chan.value;

   // Spread the low byte into one nibble per bit, top aligned
   always_comb begin
      bin_nibbles = '0;
      for (int i = 0; i < 8; i++) begin
         bin_nibbles[BCD_W-1-4*i -: 4] = {3'b000, req_chan.value[7-i]};
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      neg_in       = neg_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      pre_in       = pre_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in = req_chan.action;
               neg_in  = 1'b0;
               bcd_in  = '0;
               case (req_chan.action)
                  FMT_SIGNED_DEC: begin
                     neg_in   = req_chan.value[VALUE_W-1];
                     bin_in   = value_mag;
                     cnt_in   = 5'd31;
                     state_in = ST_CONV;
                  end
                  FMT_DEC4: begin
                     bin_in   = {req_chan.value[15:0], 16'h0000};
                     cnt_in   = 5'd15;
                     state_in = ST_CONV;
                  end
                  FMT_BIN8: begin
                     bcd_in   = bin_nibbles;
                     dig_in   = 4'd8;
                     pre_in   = 2'd0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     bcd_in   = {req_chan.value[7:0], 32'h0000_0000};
                     dig_in   = 4'd2;
                     pre_in   = 2'd2;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end

         ST_CONV: begin
            // Advance one bit of the binary-to-BCD conversion
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            bcd_in = bcd_step;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (mode_ff == FMT_SIGNED_DEC) begin
                  dig_in   = 4'd10;
                  pre_in   = {1'b0, neg_ff};
                  state_in = ST_SKIP;
               end else begin
                  bcd_in   = {bcd_step[15:0], 24'h00_0000};
                  dig_in   = 4'd4;
                  pre_in   = 2'd0;
                  state_in = ST_EMIT;
               end
            end
         end

         ST_SKIP: begin
            // Drop leading zeros, keep at least one digit
            if (bcd_ff[BCD_W-1 -: 4] == 4'd0 && dig_ff > 4'd1) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'h0};
               dig_in = dig_ff - 4'd1;
            end else begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (pre_ff != 2'd0) begin
                  // Prefix: '-' for negatives, "0X" for hex
                  if (mode_ff == FMT_HEX8) begin
                     rsp_char_in = (pre_ff == 2'd2) ? ASCII_ZERO : ASCII_UPPER_X;
                  end else begin
                     rsp_char_in = ASCII_MINUS;
                  end
                  rsp_last_in = 1'b0;
                  pre_in      = pre_ff - 2'd1;
               end else begin
                  rsp_char_in = hex_char(bcd_ff[BCD_W-1 -: 4]);
                  rsp_last_in = (dig_ff == 4'd1);
                  bcd_in      = {bcd_ff[BCD_W-5:0], 4'h0};
                  dig_in      = dig_ff - 4'd1;
                  if (dig_ff == 4'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      neg_ff      <= neg_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      dig_ff      <= dig_in;
      pre_ff      <= pre_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### tb/sv/ascii_char_checker.sv
// ----------------------------------------------------------------------------
// ascii_char_checker
// Watches the number request and character response channels, predicts the
// character stream of every accepted number and compares each accepted
// character, code and last flag, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module ascii_char_checker (
   input  logic   clock,
   input  logic   reset,
   numfmt_req_if  req_bus,
   numfmt_rsp_if  rsp_bus,
   output int     mismatch_count,
   output int     chars_pending
);
   import numfmt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      char_type code;
      logic     last;
   } glyph_type;

   // characters still owed by the block, oldest first
   glyph_type owed_chars[$];

   // Map one nibble to its upper-case hex glyph
   function automatic char_type nibble_glyph(input logic [3:0] nib);
      if (nib > 4'd9) begin
         return ASCII_UPPER_A + char_type'(nib - 4'd10);
      end
      return ASCII_ZERO + char_type'(nib);
   endfunction

   // Append the character stream of one number to the owed list
   function automatic void format_number(input logic [1:0] fmt, input word_type num);
      char_type    text[$];
      char_type    digits[$];
      word_type    mag;
      int unsigned low4;
      glyph_type   g;
      text = {};
      digits = {};
      case (fmt)
         FMT_SIGNED_DEC: begin
            mag = num;
            // magnitude as unsigned keeps the most negative value intact
            if (num[31]) begin
               text.push_back(ASCII_MINUS);
               mag = -num;
            end
            if (mag == '0) begin
               text.push_back(ASCII_ZERO);
            end else begin
               while (mag != '0) begin
                  digits.push_front(ASCII_ZERO + char_type'(mag % 10));
                  mag = mag / 10;
               end
               text = {text, digits};
            end
         end
         FMT_DEC4: begin
            low4 = int'(num[15:0]) % 10000;
            text.push_back(ASCII_ZERO + char_type'(low4 / 1000));
            text.push_back(ASCII_ZERO + char_type'((low4 % 1000) / 100));
            text.push_back(ASCII_ZERO + char_type'((low4 % 100) / 10));
            text.push_back(ASCII_ZERO + char_type'(low4 % 10));
         end
         FMT_BIN8: begin
            for (int i = 7; i >= 0; i--) begin
               text.push_back(ASCII_ZERO + char_type'(num[i]));
            end
         end
         default: begin
            text.push_back(ASCII_ZERO);
            text.push_back(ASCII_UPPER_X);
            text.push_back(nibble_glyph(num[7:4]));
            text.push_back(nibble_glyph(num[3:0]));
         end
      endcase
      foreach (text[k]) begin
         g.code = text[k];
         g.last = (k == text.size() - 1);
         owed_chars.push_back(g);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      chars_pending = 0;
   end

   // Check responses first, then queue the prediction for a new number
   always @(posedge clock) begin
      glyph_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_chars.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected char 0x%02h last=%0b", $realtime,
                           rsp_bus.char_code, rsp_bus.last);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = owed_chars.pop_front();
               if (want.code !== rsp_bus.char_code || want.last !== rsp_bus.last) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                              $realtime, want.code, want.last,
                              rsp_bus.char_code, rsp_bus.last);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            format_number(req_bus.action, req_bus.value);
         end
      end
      chars_pending <= owed_chars.size();
   end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives numbers in all four formats into the formatter, first a directed
// set of edge values, then random bursts with random gaps, while the
// response side stalls on its own pattern. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import numfmt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 240;
   localparam int DRAIN_CYCLES = 80;
   localparam int IDLE_LIMIT   = 2000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   chars_pending;
   int   idle_cycles;

   numfmt_req_if req_bus ();
   numfmt_rsp_if rsp_bus ();

   number_to_ascii_formatter_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   ascii_char_checker checker_0 (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Present one number and hold it until the block takes it
   task automatic send_number(input logic [1:0] fmt, input word_type num);
      req_bus.valid  <= 1'b1;
      req_bus.action <= fmt;
      req_bus.value  <= num;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Pick a value that leans on digit boundaries and the sign
   function automatic word_type pick_value();
      word_type    v;
      int unsigned p;
      v = $urandom();
      case ($urandom_range(0, 7))
         3: v = $urandom_range(0, 99);
         4: v = -word_type'($urandom_range(1, 9999));
         5: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         6: v = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         7: begin
            if ($urandom_range(0, 1) == 1) begin
               v[15:0] = 16'(9990 + $urandom_range(0, 20));
            end else begin
               v[15:0] = 16'hFFFF - 16'($urandom_range(0, 3));
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   // Stall the response side in runs of random length
   initial begin
      int run;
      rsp_bus.ready = 1'b0;
      forever begin
         case ($urandom_range(0, 5))
            0: begin
               run = $urandom_range(1, 8);
               rsp_bus.ready <= 1'b0;
            end
            1: begin
               run = $urandom_range(20, 60);
               rsp_bus.ready <= 1'b1;
            end
            default: begin
               run = $urandom_range(1, 6);
               rsp_bus.ready <= 1'b1;
            end
         endcase
         repeat (run) @(posedge clock);
      end
   end

   // Watchdog: end the run if nothing moves for too long
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("number_to_ascii_formatter_unit verification failed");
         $finish;
      end
   end

   // Stimulus and verdict
   initial begin
      int       burst;
      int       gap;
      int       sent;
      logic [1:0] fmt;
      req_bus.valid  = 1'b0;
      req_bus.action = FMT_SIGNED_DEC;
      req_bus.value  = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // signed decimal: zero, sign, digit-count edges, both extremes
      send_number(FMT_SIGNED_DEC, 32'd0);
      send_number(FMT_SIGNED_DEC, 32'd1);
      send_number(FMT_SIGNED_DEC, -32'sd1);
      send_number(FMT_SIGNED_DEC, 32'd9);
      send_number(FMT_SIGNED_DEC, -32'sd10);
      send_number(FMT_SIGNED_DEC, 32'd1000000000);
      send_number(FMT_SIGNED_DEC, 32'h7FFF_FFFF);
      send_number(FMT_SIGNED_DEC, 32'h8000_0000);
      // four-digit decimal: zeros kept, wrap above 9999, high bits ignored
      send_number(FMT_DEC4, 32'd0);
      send_number(FMT_DEC4, 32'd9999);
      send_number(FMT_DEC4, 32'd10000);
      send_number(FMT_DEC4, 32'd65535);
      send_number(FMT_DEC4, 32'hFFFF_0000);
      send_number(FMT_DEC4, 32'h1234_5678);
      // binary byte
      send_number(FMT_BIN8, 32'h0000_0000);
      send_number(FMT_BIN8, 32'h0000_00FF);
      send_number(FMT_BIN8, 32'h0000_00A5);
      send_number(FMT_BIN8, 32'hFFFF_FF00);
      // hex byte: digits and letters, high bits ignored
      send_number(FMT_HEX8, 32'h0000_0000);
      send_number(FMT_HEX8, 32'h0000_00FF);
      send_number(FMT_HEX8, 32'h0000_009A);
      send_number(FMT_HEX8, 32'hABCD_EF12);

      // random bursts with random gaps, some bursts back to back
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            fmt = 2'($urandom_range(0, 3));
            send_number(fmt, pick_value());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b0;

      // drain outstanding characters, then watch for strays
      do @(posedge clock); while (chars_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("number_to_ascii_formatter_unit verification clean");
      end else begin
         $display("number_to_ascii_formatter_unit verification failed");
      end
      $finish;
   end

endmodule

### number_to_ascii_formatter_unit.f
rtl/numfmt_pkg.sv
rtl/numfmt_if.sv
rtl/numfmt_dabble_step.sv
rtl/number_to_ascii_formatter_unit.sv
tb/sv/ascii_char_checker.sv
tb/sv/testbench.sv
